@@ design/arf_pkg.sv @@
// ----------------------------------------------------------------------------
// arf_pkg
// Shared types, constants and helpers of the ARMA residual filter.
// ----------------------------------------------------------------------------
package arf_pkg;

    localparam int MAX_AR       = 4;
    localparam int MAX_MA       = 4;
    localparam int MAX_LAG      = (MAX_AR > MAX_MA) ? MAX_AR : MAX_MA;
    localparam int SAMPLE_WIDTH = 32;
    localparam int COEF_WIDTH   = 16;
    localparam int COEF_SLOTS   = 4;
    localparam int FRAC_SHIFT   = 14;
    localparam int ORDER_WIDTH  = 3;
    localparam int COLUMN_WIDTH = 4;
    localparam int LIMIT_WIDTH  = 31;
    localparam int CFG_WIDTH    = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int CNT_WIDTH    = $clog2(MAX_LAG + 1);
    localparam int PROD_WIDTH   = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_WIDTH    = PROD_WIDTH + $clog2(MAX_AR + MAX_MA + 1) + 1;
    localparam int RND_WIDTH    = ACC_WIDTH - FRAC_SHIFT;
    localparam int ROUND_HALF   = 1 << (FRAC_SHIFT - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE      = 3'd0,
        CFG_AR_ORDER  = 3'd1,
        CFG_MA_ORDER  = 3'd2,
        CFG_COLUMN    = 3'd3,
        CFG_SAT_LIMIT = 3'd4,
        CFG_AR_COEFS  = 3'd5,
        CFG_MA_COEFS  = 3'd6
    } t_cfg_index;

    localparam logic MODE_RESIDUAL = 1'b0;
    localparam logic MODE_JACOBIAN = 1'b1;

    typedef struct packed {
        logic                           start_req;
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic signed [SAMPLE_WIDTH-1:0] prior_residual;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] value;
        logic                           clipped;
    } t_out_item;

    typedef struct packed {
        logic                     mode;
        logic [ORDER_WIDTH-1:0]   ar_order;
        logic [ORDER_WIDTH-1:0]   ma_order;
        logic [COLUMN_WIDTH-1:0]  column;
        logic [LIMIT_WIDTH-1:0]   sat_limit;
        logic [CFG_WIDTH-1:0]     ar_coefs;
        logic [CFG_WIDTH-1:0]     ma_coefs;
    } t_cfg;

    typedef logic [MAX_AR-1:0][SAMPLE_WIDTH-1:0] t_ar_line;
    typedef logic [MAX_MA-1:0][SAMPLE_WIDTH-1:0] t_ma_line;

    function automatic logic [ORDER_WIDTH-1:0] clamp_order(
        input logic [ORDER_WIDTH-1:0] order,
        input int                     limit
    );
        if (int'(order) > limit) begin
            return ORDER_WIDTH'(limit);
        end
        return order;
    endfunction

endpackage

@@ design/arma_residual_filter.sv @@
// ----------------------------------------------------------------------------
// arma_residual_filter
// ARMA residual / Jacobian column filter, Q16.16 samples, Q2.14 coefficients.
//
//   channel  direction  handshake                     payload
//   in       input      i_in_valid / o_in_ready       i_in_data   (t_in_item)
//   out      output     o_out_valid / i_out_ready     o_out_data  (t_out_item)
//   cfg      input      i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// One sample per cycle sustained; a result is registered once its sample has
// passed the input register and then the result register. The residual
// feedback through the delay lines and the eight tap multipliers closes
// combinationally between those registers. Warm-up samples give no result.
// Synchronous reset clears the delay lines, counter and handshakes; a full
// result register stalls the input register, which then drops ready.
// ----------------------------------------------------------------------------
module arma_residual_filter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  arf_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output arf_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [arf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [arf_pkg::CFG_WIDTH-1:0] i_cfg_data
);
    import arf_pkg::*;

    t_cfg       cfg;
    t_in_item   r_in;
    logic       r_in_valid;
    t_out_item  r_out;
    logic       r_out_valid;
    logic       step;
    logic       warm;
    t_ar_line   sample_line;
    t_ma_line   resid_line;
    t_ma_line   col_line;
    t_out_item  result;

    assign o_cfg_ready = 1'b1;

    arf_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    arf_delay_lines u_lines (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_step        (step),
        .i_start       (r_in.start_req),
        .i_sample      (r_in.sample),
        .i_prior       (r_in.prior_residual),
        .i_result      (result.value),
        .o_warm        (warm),
        .o_sample_line (sample_line),
        .o_resid_line  (resid_line),
        .o_col_line    (col_line)
    );

    arf_mac u_mac (
        .i_cfg         (cfg),
        .i_sample      (r_in.sample),
        .i_sample_line (sample_line),
        .i_resid_line  (resid_line),
        .i_col_line    (col_line),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step && !warm) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (step && !warm) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ design/arf_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// arf_cfg_regs
// Configuration register file, written one register per transaction.
// ----------------------------------------------------------------------------
module arf_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [arf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [arf_pkg::CFG_WIDTH-1:0] i_cfg_data,
    output arf_pkg::t_cfg                 o_cfg
);
    import arf_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode      <= MODE_RESIDUAL;
            r_cfg.ar_order  <= '0;
            r_cfg.ma_order  <= '0;
            r_cfg.column    <= COLUMN_WIDTH'(1);
            r_cfg.sat_limit <= '1;
            r_cfg.ar_coefs  <= '0;
            r_cfg.ma_coefs  <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_MODE:      r_cfg.mode      <= i_cfg_data[0];
                CFG_AR_ORDER:  r_cfg.ar_order  <= i_cfg_data[ORDER_WIDTH-1:0];
                CFG_MA_ORDER:  r_cfg.ma_order  <= i_cfg_data[ORDER_WIDTH-1:0];
                CFG_COLUMN:    r_cfg.column    <= i_cfg_data[COLUMN_WIDTH-1:0];
                CFG_SAT_LIMIT: r_cfg.sat_limit <= i_cfg_data[LIMIT_WIDTH-1:0];
                CFG_AR_COEFS:  r_cfg.ar_coefs  <= i_cfg_data;
                CFG_MA_COEFS:  r_cfg.ma_coefs  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ design/arf_delay_lines.sv @@
// ----------------------------------------------------------------------------
// arf_delay_lines
// Sample, residual and column delay lines plus the warm-up counter.
// ----------------------------------------------------------------------------
module arf_delay_lines (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  arf_pkg::t_cfg                          i_cfg,
    input  logic                                   i_step,
    input  logic                                   i_start,
    input  logic signed [arf_pkg::SAMPLE_WIDTH-1:0] i_sample,
    input  logic signed [arf_pkg::SAMPLE_WIDTH-1:0] i_prior,
    input  logic signed [arf_pkg::SAMPLE_WIDTH-1:0] i_result,
    output logic                                   o_warm,
    output arf_pkg::t_ar_line                      o_sample_line,
    output arf_pkg::t_ma_line                      o_resid_line,
    output arf_pkg::t_ma_line                      o_col_line
);
    import arf_pkg::*;

    t_ar_line               r_sample_line;
    t_ma_line               r_resid_line;
    t_ma_line               r_col_line;
    logic [CNT_WIDTH-1:0]   r_count;

    logic [CNT_WIDTH-1:0]   cnt_eff;
    logic [ORDER_WIDTH-1:0] p;
    logic [ORDER_WIDTH-1:0] q;
    logic [ORDER_WIDTH-1:0] maxpq;
    logic signed [SAMPLE_WIDTH-1:0] resid_in;

    assign p     = clamp_order(i_cfg.ar_order, MAX_AR);
    assign q     = clamp_order(i_cfg.ma_order, MAX_MA);
    assign maxpq = (p > q) ? p : q;

    // a start flag clears the lines before this sample is used
    assign cnt_eff       = i_start ? '0 : r_count;
    assign o_sample_line = i_start ? '0 : r_sample_line;
    assign o_resid_line  = i_start ? '0 : r_resid_line;
    assign o_col_line    = i_start ? '0 : r_col_line;
    assign o_warm        = (8'(cnt_eff) < 8'(maxpq));

    assign resid_in = (i_cfg.mode == MODE_JACOBIAN) ? i_prior : i_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_line <= '0;
            r_resid_line  <= '0;
            r_col_line    <= '0;
            r_count       <= '0;
        end else if (i_step) begin
            r_sample_line <= {o_sample_line[MAX_AR-2:0], i_sample};
            if (o_warm) begin
                r_count      <= cnt_eff + CNT_WIDTH'(1);
                r_resid_line <= o_resid_line;
                r_col_line   <= o_col_line;
            end else begin
                r_count      <= cnt_eff;
                r_resid_line <= {o_resid_line[MAX_MA-2:0], resid_in};
                if (i_cfg.mode == MODE_JACOBIAN) begin
                    r_col_line <= {o_col_line[MAX_MA-2:0], i_result};
                end else begin
                    r_col_line <= o_col_line;
                end
            end
        end
    end

endmodule

@@ design/arf_mac.sv @@
// ----------------------------------------------------------------------------
// arf_mac
// Parallel tap multipliers, accumulation, rounding and saturation.
// ----------------------------------------------------------------------------
module arf_mac (
    input  arf_pkg::t_cfg                           i_cfg,
    input  logic signed [arf_pkg::SAMPLE_WIDTH-1:0] i_sample,
    input  arf_pkg::t_ar_line                       i_sample_line,
    input  arf_pkg::t_ma_line                       i_resid_line,
    input  arf_pkg::t_ma_line                       i_col_line,
    output arf_pkg::t_out_item                      o_result
);
    import arf_pkg::*;

    logic [ORDER_WIDTH-1:0]        p;
    logic [ORDER_WIDTH-1:0]        q;
    logic signed [COEF_WIDTH-1:0]  ar_coef [MAX_AR];
    logic signed [COEF_WIDTH-1:0]  ma_coef [MAX_MA];
    logic signed [PROD_WIDTH-1:0]  ar_term [MAX_AR];
    logic signed [PROD_WIDTH-1:0]  ma_term [MAX_MA];
    logic signed [SAMPLE_WIDTH:0]  drive;
    logic signed [SAMPLE_WIDTH:0]  base;
    logic signed [ACC_WIDTH-1:0]   acc;
    logic signed [ACC_WIDTH-1:0]   acc_rnd;
    logic signed [RND_WIDTH-1:0]   rnd;
    logic signed [RND_WIDTH-1:0]   lim_pos;
    logic signed [RND_WIDTH-1:0]   lim_neg;
    logic                          jac;

    assign p   = clamp_order(i_cfg.ar_order, MAX_AR);
    assign q   = clamp_order(i_cfg.ma_order, MAX_MA);
    assign jac = (i_cfg.mode == MODE_JACOBIAN);

    for (genvar k = 0; k < MAX_AR; k++) begin : g_ar
        if (k < COEF_SLOTS) begin : g_coef
            assign ar_coef[k] = $signed(i_cfg.ar_coefs[k*COEF_WIDTH +: COEF_WIDTH]);
        end else begin : g_zero
            assign ar_coef[k] = '0;
        end
        assign ar_term[k] = (!jac && k < int'(p))
                          ? ar_coef[k] * $signed(i_sample_line[k])
                          : $signed({PROD_WIDTH{1'b0}});
    end

    for (genvar k = 0; k < MAX_MA; k++) begin : g_ma
        if (k < COEF_SLOTS) begin : g_coef
            assign ma_coef[k] = $signed(i_cfg.ma_coefs[k*COEF_WIDTH +: COEF_WIDTH]);
        end else begin : g_zero
            assign ma_coef[k] = '0;
        end
        assign ma_term[k] = (k < int'(q))
                          ? ma_coef[k] * $signed(jac ? i_col_line[k] : i_resid_line[k])
                          : $signed({PROD_WIDTH{1'b0}});
    end

    // drive term of the selected column
    always_comb begin
        drive = '0;
        for (int k = 0; k < MAX_MA; k++) begin
            if ({1'b0, i_cfg.column} == 5'(k + 1) && k < int'(q)) begin
                drive = (SAMPLE_WIDTH + 1)'($signed(i_resid_line[k]));
            end
        end
        for (int k = 0; k < MAX_AR; k++) begin
            if ({1'b0, i_cfg.column} == 5'(q) + 5'(k + 1) && k < int'(p)) begin
                drive = -((SAMPLE_WIDTH + 1)'($signed(i_sample_line[k])));
            end
        end
    end

    assign base = jac ? drive : (SAMPLE_WIDTH + 1)'(i_sample);

    always_comb begin
        acc = ACC_WIDTH'(base) <<< FRAC_SHIFT;
        for (int k = 0; k < MAX_AR; k++) begin
            acc = acc - ACC_WIDTH'(ar_term[k]);
        end
        for (int k = 0; k < MAX_MA; k++) begin
            acc = acc + ACC_WIDTH'(ma_term[k]);
        end
    end

    assign acc_rnd = acc + ACC_WIDTH'(ROUND_HALF);
    assign rnd     = RND_WIDTH'(acc_rnd >>> FRAC_SHIFT);
    assign lim_pos = $signed(RND_WIDTH'({1'b0, i_cfg.sat_limit}));
    assign lim_neg = -lim_pos;

    always_comb begin
        if (rnd > lim_pos) begin
            o_result.value   = lim_pos[SAMPLE_WIDTH-1:0];
            o_result.clipped = 1'b1;
        end else if (rnd < lim_neg) begin
            o_result.value   = lim_neg[SAMPLE_WIDTH-1:0];
            o_result.clipped = 1'b1;
        end else begin
            o_result.value   = rnd[SAMPLE_WIDTH-1:0];
            o_result.clipped = 1'b0;
        end
    end

endmodule

@@ test/tb_arma_residual_filter.sv @@
// ----------------------------------------------------------------------------
// tb_arma_residual_filter
// Self-checking bench for the ARMA residual / Jacobian column filter: a
// directed pass over field extremes and corner configurations, then random
// series under many register settings. Every accepted sample is run through a
// bit-exact Q16.16 predictor, and results are checked in order against it
// while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_arma_residual_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import arf_pkg::*;

    localparam int          RUN_ITEMS      = 800;
    localparam int          SETTLE_CYCLES  = 4;
    localparam int          HOLD_CYCLES    = 150;
    localparam int unsigned TIMEOUT_CYCLES = 400_000;

    typedef enum int {Y_LINE = 0, A_LINE = 1, J_LINE = 2} t_line;

    class arma_tracker;
        t_cfg       regs;
        longint     hist[3][MAX_LAG];
        int         warm;
        t_out_item  expected_q[$];
        int         errors;
        int         samples_in;
        int         results_seen;
        int         clips_seen;
        int         writes;

        function new();
            regs           = '0;
            regs.column    = COLUMN_WIDTH'(1);
            regs.sat_limit = '1;
            errors         = 0;
            samples_in     = 0;
            results_seen   = 0;
            clips_seen     = 0;
            writes         = 0;
            clear_lines();
        endfunction

        function void clear_lines();
            foreach (hist[i, j]) hist[i][j] = 0;
            warm = 0;
        endfunction

        function void push(t_line which, longint v);
            for (int i = MAX_LAG - 1; i > 0; i--) hist[which][i] = hist[which][i-1];
            hist[which][0] = v;
        endfunction

        function longint tap(logic [CFG_WIDTH-1:0] bank, int lag);
            return longint'($signed(bank[COEF_WIDTH*(lag-1) +: COEF_WIDTH]));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void apply_reg(t_cfg_index idx, logic [CFG_WIDTH-1:0] d);
            writes++;
            case (idx)
                CFG_MODE:      regs.mode      = d[0];
                CFG_AR_ORDER:  regs.ar_order  = d[ORDER_WIDTH-1:0];
                CFG_MA_ORDER:  regs.ma_order  = d[ORDER_WIDTH-1:0];
                CFG_COLUMN:    regs.column    = d[COLUMN_WIDTH-1:0];
                CFG_SAT_LIMIT: regs.sat_limit = d[LIMIT_WIDTH-1:0];
                CFG_AR_COEFS:  regs.ar_coefs  = d;
                CFG_MA_COEFS:  regs.ma_coefs  = d;
                default: ;
            endcase
        endfunction

        function void take_sample(t_in_item it);
            int        p;
            int        q;
            int        maxpq;
            int        col;
            longint    acc;
            longint    drive;
            longint    r;
            longint    lim;
            t_out_item res;
            samples_in++;
            p     = (int'(regs.ar_order) > MAX_AR) ? MAX_AR : int'(regs.ar_order);
            q     = (int'(regs.ma_order) > MAX_MA) ? MAX_MA : int'(regs.ma_order);
            maxpq = (p > q) ? p : q;
            if (it.start_req) begin
                clear_lines();
            end
            if (warm < maxpq) begin
                warm++;
                push(Y_LINE, longint'($signed(it.sample)));
                return;
            end
            if (regs.mode == MODE_RESIDUAL) begin
                acc = longint'($signed(it.sample)) * 16384;
                for (int l = 1; l <= p; l++) acc -= tap(regs.ar_coefs, l) * hist[Y_LINE][l-1];
                for (int l = 1; l <= q; l++) acc += tap(regs.ma_coefs, l) * hist[A_LINE][l-1];
            end else begin
                col   = int'(regs.column);
                drive = 0;
                if (col >= 1 && col <= q) begin
                    drive = hist[A_LINE][col-1];
                end else if (col > q && col <= q + p) begin
                    drive = -hist[Y_LINE][col-q-1];
                end
                acc = drive * 16384;
                for (int l = 1; l <= q; l++) acc += tap(regs.ma_coefs, l) * hist[J_LINE][l-1];
            end
            // sum stays far inside 64 bits, so no accumulator saturation
            r             = (acc + 8192) >>> 14;
            lim           = longint'(regs.sat_limit);
            res.clipped   = 1'b0;
            if (r > lim) begin
                r           = lim;
                res.clipped = 1'b1;
            end else if (r < -lim) begin
                r           = -lim;
                res.clipped = 1'b1;
            end
            res.value = r[SAMPLE_WIDTH-1:0];
            if (regs.mode == MODE_RESIDUAL) begin
                push(A_LINE, r);
            end else begin
                push(A_LINE, longint'($signed(it.prior_residual)));
                push(J_LINE, r);
            end
            push(Y_LINE, longint'($signed(it.sample)));
            expected_q.push_back(res);
        endfunction

        function void match_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                $error("unexpected result: value %0d clipped %0b",
                       $signed(got.value), got.clipped);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            results_seen++;
            if (got.clipped) clips_seen++;
            if (got.value !== want.value) begin
                $error("value: expected %0d, got %0d", $signed(want.value), $signed(got.value));
                errors++;
            end
            if (got.clipped !== want.clipped) begin
                $error("clipped: expected %0b, got %0b", want.clipped, got.clipped);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_WIDTH-1:0]  i_cfg_data = '0;

    arma_tracker book = new();
    int          items_sent = 0;
    int          burst_left = 0;
    int          hold_off_cycles = 0;
    int unsigned cycle_count = 0;

    arma_residual_filter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) book.apply_reg(t_cfg_index'(i_cfg_index), i_cfg_data);
            if (i_in_valid && o_in_ready) book.take_sample(i_in_data);
            if (o_out_valid && i_out_ready) book.match_result(o_out_data);
        end
    end

    initial begin : watchdog
        wait (cycle_count >= TIMEOUT_CYCLES);
        $error("timeout with %0d results outstanding", book.pending());
        $display("tb: failure");
        $finish;
    end

    // receiver: changing stall styles, plus a long hold-off on request
    initial begin : out_pacing
        int style;
        int style_left;
        int tick;
        int hold;
        style      = 0;
        style_left = 0;
        tick       = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles != 0) begin
                hold            = hold_off_cycles;
                hold_off_cycles = 0;
                i_out_ready     = 1'b0;
                repeat (hold - 1) @(negedge i_clk);
            end else begin
                if (style_left == 0) begin
                    style      = $urandom_range(0, 3);
                    style_left = $urandom_range(20, 150);
                end
                style_left--;
                tick++;
                case (style)
                    0:       i_out_ready = 1'b1;
                    1:       i_out_ready = ($urandom_range(0, 3) != 0);
                    2:       i_out_ready = ((tick % 7) < 4);
                    default: i_out_ready = 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    task automatic drive_sample(input logic start, input logic [31:0] y,
                                input logic [31:0] prior);
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_data  = '{start_req: start, sample: y, prior_residual: prior};
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic idle_input(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
    endtask

    task automatic feed(input logic start, input logic [31:0] y, input logic [31:0] prior);
        if (burst_left == 0) begin
            idle_input(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        drive_sample(start, y, prior);
    endtask

    task automatic quiesce();
        idle_input(1);
        while (book.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_index idx, input logic [CFG_WIDTH-1:0] d);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = d;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return 32'($signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000);
        endcase
    endfunction

    function automatic logic [CFG_WIDTH-1:0] pick_coefs();
        logic [CFG_WIDTH-1:0] bank;
        for (int s = 0; s < COEF_SLOTS; s++) begin
            case ($urandom_range(0, 9))
                0:       bank[16*s +: 16] = 16'($urandom);
                1:       bank[16*s +: 16] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                default: bank[16*s +: 16] = 16'($signed($urandom_range(0, 16'h0600)) - 16'sh0300);
            endcase
        end
        return bank;
    endfunction

    function automatic logic [CFG_WIDTH-1:0] pick_limit();
        case ($urandom_range(0, 7))
            0:       return 64'd0;
            1:       return 64'($urandom_range(1, 32'h000F_FFFF));
            2:       return 64'($urandom & 32'h7FFF_FFFF);
            3:       return 64'($urandom_range(1, 32'h0100_0000));
            default: return 64'h7FFF_FFFF;
        endcase
    endfunction

    task automatic random_phase(input int n_items, input bit pressure);
        int   series_left;
        logic start;
        series_left = 0;
        cfg_write(CFG_MODE, 64'($urandom_range(0, 1)));
        cfg_write(CFG_AR_ORDER, 64'($urandom_range(0, 7)));
        cfg_write(CFG_MA_ORDER, 64'($urandom_range(0, 7)));
        cfg_write(CFG_COLUMN, ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 15))
                                                           : 64'($urandom_range(1, 8)));
        cfg_write(CFG_SAT_LIMIT, pick_limit());
        cfg_write(CFG_AR_COEFS, pick_coefs());
        cfg_write(CFG_MA_COEFS, pick_coefs());
        if (pressure) begin
            hold_off_cycles = HOLD_CYCLES;
            burst_left      = n_items + 1;
        end
        for (int k = 0; k < n_items; k++) begin
            if (series_left == 0) begin
                series_left = $urandom_range(1, 24);
                // a phase may carry on the previous series under new orders
                start = (k != 0) || ($urandom_range(0, 3) != 0);
            end else begin
                start = ($urandom_range(0, 39) == 0);
            end
            series_left--;
            if (pressure && k == n_items / 2) quiesce();
            feed(start, pick_value(), pick_value());
        end
    endtask

    initial begin : main
        int directed_items;
        int phase_no;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset registers: no taps, result equals sample save that 32'h8000_0000 clips at the full-scale limit
        drive_sample(1'b1, 32'h7FFF_FFFF, 32'h0000_0000);
        drive_sample(1'b0, 32'h8000_0000, 32'hFFFF_FFFF);
        drive_sample(1'b0, 32'h0000_0000, 32'h7FFF_FFFF);
        drive_sample(1'b0, 32'hFFFF_FFFF, 32'h8000_0000);
        drive_sample(1'b0, 32'h0001_0000, 32'h0000_0000);
        quiesce();

        // oversized AR order clamps, extreme coefficients, tight limit
        cfg_write(CFG_AR_ORDER, 64'd7);
        cfg_write(CFG_MA_ORDER, 64'd4);
        cfg_write(CFG_AR_COEFS, 64'h8000_7FFF_8000_7FFF);
        cfg_write(CFG_MA_COEFS, 64'h7FFF_8000_7FFF_8000);
        cfg_write(CFG_SAT_LIMIT, 64'h0010_0000);
        drive_sample(1'b1, 32'h7FFF_FFFF, 32'h0000_0000);
        drive_sample(1'b0, 32'h8000_0000, 32'h0000_0000);
        drive_sample(1'b0, 32'h0001_0000, 32'h0000_0000);
        drive_sample(1'b0, 32'hFFFF_0000, 32'h0000_0000);
        drive_sample(1'b0, 32'h7FFF_FFFF, 32'h0000_0000);
        drive_sample(1'b0, 32'h8000_0000, 32'h0000_0000);
        drive_sample(1'b0, 32'h0000_0000, 32'h0000_0000);
        drive_sample(1'b0, 32'h1234_5678, 32'h0000_0000);
        quiesce();

        // Jacobian: column zero, past q+p, an MA column, an AR column
        cfg_write(CFG_SAT_LIMIT, 64'h7FFF_FFFF);
        cfg_write(CFG_MA_COEFS, 64'h0400_FC00_0200_1000);
        cfg_write(CFG_MODE, 64'(MODE_JACOBIAN));
        cfg_write(CFG_COLUMN, 64'd0);
        drive_sample(1'b0, 32'h0002_0000, 32'h7FFF_FFFF);
        drive_sample(1'b0, 32'hFFFE_0000, 32'h8000_0000);
        quiesce();
        cfg_write(CFG_COLUMN, 64'd9);
        drive_sample(1'b0, 32'h0003_0000, 32'h0001_0000);
        quiesce();
        cfg_write(CFG_COLUMN, 64'd2);
        drive_sample(1'b0, 32'h0004_0000, 32'hFFFF_FFFF);
        drive_sample(1'b0, 32'h8000_0000, 32'h0000_8000);
        quiesce();
        cfg_write(CFG_COLUMN, 64'd6);
        drive_sample(1'b0, 32'h7FFF_FFFF, 32'h0000_0000);
        drive_sample(1'b0, 32'hFFFF_8000, 32'h0000_0000);
        quiesce();

        // zero limit forces every nonzero result to clip
        cfg_write(CFG_MODE, 64'(MODE_RESIDUAL));
        cfg_write(CFG_SAT_LIMIT, 64'd0);
        drive_sample(1'b1, 32'h0001_0000, 32'h0000_0000);
        drive_sample(1'b0, 32'h0000_0000, 32'h0000_0000);
        drive_sample(1'b0, 32'h0000_0000, 32'h0000_0000);
        drive_sample(1'b0, 32'h0000_0000, 32'h0000_0000);
        drive_sample(1'b0, 32'hFFFF_0000, 32'h0000_0000);
        directed_items = items_sent;

        phase_no = 0;
        while (items_sent - directed_items < RUN_ITEMS) begin
            quiesce();
            random_phase($urandom_range(30, 90), phase_no == 3);
            phase_no++;
        end
        quiesce();
        repeat (10) @(posedge i_clk);

        if (book.pending() != 0) begin
            $error("%0d expected results never arrived", book.pending());
            book.errors++;
        end
        $display("run: %0d samples over %0d random phases, %0d results checked (%0d clipped)",
                 book.samples_in, phase_no, book.results_seen, book.clips_seen);
        $display("run: %0d register writes, %0d errors", book.writes, book.errors);
        if (book.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
